FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWVS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SWVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/swvs_pkg.sv
package swvs_pkg;

   localparam int SAMPLE_W           = 32;
   localparam int WIN_W              = 11;
   localparam int CNT_W              = 12;
   localparam int TOTAL_W            = 44;
   localparam int VAR_W              = 63;
   localparam int FRAC_W             = 16;
   localparam int MAG_A_W            = 33;
   localparam int MAG_B_W            = 34;
   localparam int PROD_W             = MAG_A_W + MAG_B_W;
   localparam int SQ_W               = PROD_W - FRAC_W;
   localparam int DIV_CNT_W          = 6;
   localparam int WINDOW_MAX_DEFAULT = 2048;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(730);
   localparam logic [WIN_W-1:0] WINDOW_MIN   = WIN_W'(2);
   localparam logic [CNT_W-1:0] COUNT_MAX    = CNT_W'(4095);
   localparam logic [VAR_W-1:0] VAR_MAX      = {VAR_W{1'b1}};

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: sv/swvs_div.sv
module swvs_div
   import swvs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TOTAL_W-1:0]   dividend,
   input  logic [WIN_W-1:0]     divisor,
   output logic [TOTAL_W-1:0]   quotient,
   output div_stat_type         status
);

   logic [WIN_W-1:0]     rem_ff;
   logic [TOTAL_W-1:0]   quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [WIN_W:0]       trial;
   logic                 fits;
   logic [WIN_W:0]       rem_in;

   assign trial  = {rem_ff, quo_ff[TOTAL_W-1]};
   assign fits   = trial >= {1'b0, divisor};
   assign rem_in = fits ? trial - {1'b0, divisor} : trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= '0;
            quo_ff <= dividend;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= rem_in[WIN_W-1:0];
            quo_ff <= {quo_ff[TOTAL_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(TOTAL_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = run_ff;
   assign status.done = done_ff;

endmodule

FILE: sv/swvs_store.sv
module swvs_store
   import swvs_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(WINDOW_MAX)-1:0] wr_addr,
   input  logic [SAMPLE_W-1:0]           wr_data,
   input  logic [$clog2(WINDOW_MAX)-1:0] rd_addr,
   output logic [SAMPLE_W-1:0]           rd_data
);

   logic [SAMPLE_W-1:0] mem_ff [WINDOW_MAX];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sliding_window_variance_sum.sv
// Sliding-window mean and sum of squared deviations over signed Q16.16 samples.
// One transaction in gives one transaction out. A sample that is absent, or
// that does not yet complete a full window of valid samples, answers with
// result_ready low. A full window is accepted and passes through the
// bit-per-cycle divider that forms the mean, and then either takes the
// incremental update or, for the first result of a run, walks the whole
// window through the single memory read port and the one shared multiplier
// (the window length is clamped to [2, WINDOW_MAX-1]). A finished
// transaction waits until the output register is free and then moves into
// it; the next one is taken as soon as it has moved there.
module sliding_window_variance_sum
   import swvs_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_sample_valid,
   input  logic                       req_series_start,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_result_ready,
   output logic signed [SAMPLE_W-1:0] rsp_window_mean,
   output logic [VAR_W-1:0]           rsp_variance_sum,
   input  logic                       csr_write_enable,
   input  logic [WIN_W-1:0]           csr_write_data
);

`include "assert_macros.svh"

   localparam int AW  = $clog2(WINDOW_MAX);
   localparam int AXW = ((AW > WIN_W) ? AW : WIN_W) + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_OLD, S_SUB, S_XO, S_MUL, S_ACC, S_WALK, S_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [WIN_W-1:0]           win_len_ff;
   logic [AW-1:0]              wptr_ff, idx_ff;
   logic [CNT_W-1:0]           valid_seen_ff;
   logic signed [TOTAL_W-1:0]  total_ff;
   logic signed [SAMPLE_W-1:0] x_ff, mean_ff, prev_mean_ff;
   logic [VAR_W-1:0]           var_ff;
   logic                       first_done_ff;
   logic                       res_ready_ff;
   logic [WIN_W-1:0]           k_ff;
   logic                       rd_v_ff, op_v_ff, prod_v_ff;
   logic [MAG_A_W-1:0]         mul_a_ff;
   logic [MAG_B_W-1:0]         mul_b_ff;
   logic                       neg_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic                       rsp_valid_ff, rsp_result_ready_ff;
   logic signed [SAMPLE_W-1:0] rsp_window_mean_ff;
   logic [VAR_W-1:0]           rsp_variance_sum_ff;

   logic                       accept;
   logic [WIN_W-1:0]           w_eff;
   logic signed [TOTAL_W-1:0]  total_base, total_new;
   logic [TOTAL_W-1:0]         total_mag;
   logic [CNT_W-1:0]           vs_base, vs_new;
   logic                       full;
   logic [AW-1:0]              idx_acc, wptr_next;
   logic [WIN_W-1:0]           rd_off;
   logic [AXW-1:0]             rd_diff;
   logic [AW-1:0]              rd_addr;
   logic [SAMPLE_W-1:0]        rd_data;
   logic signed [SAMPLE_W-1:0] rd_s;
   logic                       issue, walk_done, out_free;
   logic signed [MAG_A_W-1:0]  d_walk, a_s;
   logic signed [MAG_B_W-1:0]  b_s;
   logic [SQ_W-1:0]            sq;
   logic [VAR_W:0]             var_add;
   logic [VAR_W-1:0]           var_add_sat, var_sub;
   logic [TOTAL_W-1:0]         div_q, div_q_s;
   div_stat_type               div_stat;
   logic                       div_start;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      priority if (win_len_ff < WINDOW_MIN) begin
         w_eff = WINDOW_MIN;
      end else if (int'(win_len_ff) > WINDOW_MAX - 1) begin
         w_eff = WIN_W'(WINDOW_MAX - 1);
      end else begin
         w_eff = win_len_ff;
      end
   end

   assign total_base = req_series_start ? '0 : total_ff;
   assign total_new  = total_base + TOTAL_W'(req_sample);
   assign total_mag  = total_new[TOTAL_W-1] ? -total_new : total_new;
   assign vs_base    = req_series_start ? '0 : valid_seen_ff;
   assign vs_new     = (vs_base == COUNT_MAX) ? vs_base : vs_base + 1'b1;
   assign full       = vs_new >= CNT_W'(w_eff);
   assign idx_acc    = req_series_start ? '0 : wptr_ff;
   assign wptr_next  = (idx_acc == AW'(WINDOW_MAX - 1)) ? '0 : idx_acc + 1'b1;
   assign div_start  = accept && req_sample_valid && full;

   always_comb begin
      unique case (state_ff)
         S_SUB:   rd_off = w_eff;
         S_WALK:  rd_off = k_ff;
         default: rd_off = w_eff - 1'b1;
      endcase
   end

   assign rd_diff = AXW'(idx_ff) - AXW'(rd_off);
   assign rd_addr = rd_diff[AXW-1] ? AW'(rd_diff + AXW'(WINDOW_MAX)) : AW'(rd_diff);
   assign rd_s    = $signed(rd_data);

   assign issue     = (state_ff == S_WALK) && (k_ff < w_eff);
   assign walk_done = (state_ff == S_WALK) && !issue && !rd_v_ff && !op_v_ff && !prod_v_ff;

   assign d_walk = MAG_A_W'(rd_s) - MAG_A_W'(mean_ff);
   assign a_s    = MAG_A_W'(x_ff) - MAG_A_W'(rd_s);
   assign b_s    = MAG_B_W'(x_ff) - MAG_B_W'(mean_ff) + MAG_B_W'(rd_s)
                   - MAG_B_W'(prev_mean_ff);

   assign sq          = prod_ff[PROD_W-1:FRAC_W];
   assign var_add     = {1'b0, var_ff} + (VAR_W + 1)'(sq);
   assign var_add_sat = var_add[VAR_W] ? VAR_MAX : var_add[VAR_W-1:0];
   assign var_sub     = (var_ff >= VAR_W'(sq)) ? var_ff - VAR_W'(sq) : '0;

   assign div_q_s = total_ff[TOTAL_W-1] ? -div_q : div_q;

   swvs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_mag),
      .divisor  (w_eff),
      .quotient (div_q),
      .status   (div_stat)
   );

   swvs_store #(.WINDOW_MAX(WINDOW_MAX)) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (idx_acc),
      .wr_data (req_sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            state_in = div_start ? S_DIV : S_DONE;
         end
         S_DIV:  if (div_stat.done) begin
            state_in = S_OLD;
         end
         S_OLD:  state_in = S_SUB;
         S_SUB:  state_in = first_done_ff ? S_XO : S_WALK;
         S_XO:   state_in = S_MUL;
         S_MUL:  state_in = S_ACC;
         S_ACC:  state_in = S_DONE;
         S_WALK: if (walk_done) begin
            state_in = S_DONE;
         end
         S_DONE: if (out_free) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         win_len_ff    <= WINDOW_RESET;
         wptr_ff       <= '0;
         valid_seen_ff <= '0;
         total_ff      <= '0;
         prev_mean_ff  <= '0;
         var_ff        <= '0;
         first_done_ff <= 1'b0;
         res_ready_ff  <= 1'b0;
         k_ff          <= '0;
         rd_v_ff       <= 1'b0;
         op_v_ff       <= 1'b0;
         prod_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_v_ff   <= issue;
         op_v_ff   <= rd_v_ff && (state_ff == S_WALK);
         prod_v_ff <= op_v_ff;
         prod_ff   <= PROD_W'(mul_a_ff) * PROD_W'(mul_b_ff);
         if ((state_ff == S_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: if (accept) begin
               x_ff    <= req_sample;
               idx_ff  <= idx_acc;
               wptr_ff <= wptr_next;
               if (!req_sample_valid) begin
                  valid_seen_ff <= '0;
                  total_ff      <= '0;
                  prev_mean_ff  <= '0;
                  var_ff        <= '0;
                  first_done_ff <= 1'b0;
                  res_ready_ff  <= 1'b0;
               end else begin
                  valid_seen_ff <= vs_new;
                  total_ff      <= total_new;
                  res_ready_ff  <= full;
                  if (req_series_start) begin
                     prev_mean_ff  <= '0;
                     var_ff        <= '0;
                     first_done_ff <= 1'b0;
                  end
               end
            end
            S_DIV: if (div_stat.done) begin
               mean_ff <= div_q_s[SAMPLE_W-1:0];
            end
            S_SUB: begin
               total_ff <= total_ff - TOTAL_W'(rd_s);
               k_ff     <= '0;
               if (!first_done_ff) begin
                  var_ff <= '0;
               end
            end
            S_XO: begin
               mul_a_ff <= a_s[MAG_A_W-1] ? MAG_A_W'(-a_s) : MAG_A_W'(a_s);
               mul_b_ff <= b_s[MAG_B_W-1] ? MAG_B_W'(-b_s) : MAG_B_W'(b_s);
               neg_ff   <= a_s[MAG_A_W-1] ^ b_s[MAG_B_W-1];
            end
            S_ACC: begin
               var_ff       <= neg_ff ? var_sub : var_add_sat;
               prev_mean_ff <= mean_ff;
            end
            S_WALK: begin
               if (issue) begin
                  k_ff <= k_ff + 1'b1;
               end
               if (rd_v_ff) begin
                  mul_a_ff <= d_walk[MAG_A_W-1] ? MAG_A_W'(-d_walk) : MAG_A_W'(d_walk);
                  mul_b_ff <= d_walk[MAG_A_W-1] ? MAG_B_W'(MAG_A_W'(-d_walk))
                                                : MAG_B_W'(MAG_A_W'(d_walk));
               end
               if (prod_v_ff) begin
                  var_ff <= var_add_sat;
               end
               if (walk_done) begin
                  first_done_ff <= 1'b1;
                  prev_mean_ff  <= mean_ff;
               end
            end
            S_DONE: if (out_free) begin
               rsp_result_ready_ff <= res_ready_ff;
               rsp_window_mean_ff  <= res_ready_ff ? mean_ff : '0;
               rsp_variance_sum_ff <= res_ready_ff ? var_ff : '0;
            end
            default: ;
         endcase
         if (csr_write_enable) begin
            win_len_ff    <= csr_write_data;
            valid_seen_ff <= '0;
            total_ff      <= '0;
            prev_mean_ff  <= '0;
            var_ff        <= '0;
            first_done_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_ready = rsp_result_ready_ff;
   assign rsp_window_mean  = rsp_window_mean_ff;
   assign rsp_variance_sum = rsp_variance_sum_ff;

   `SWVS_ASSERT_IMPL(a_ready_div_idle, clock, reset, req_ready, !div_stat.busy)
   `SWVS_ASSERT_NEXT(a_accept_blocks, clock, reset, req_valid && req_ready, !req_ready)
   `SWVS_ASSERT_IMPL(a_zero_not_ready, clock, reset, rsp_valid && !rsp_result_ready,
                     rsp_window_mean == '0 && rsp_variance_sum == '0)
   `SWVS_ASSERT_IMPL(a_done_in_div, clock, reset, div_stat.done, state_ff == S_DIV)

endmodule
